>>> hdl/bounded_stack_with_palindrome_check_defines.svh
// Assertion macros for the bounded stack block.
// Self-contained; the top level includes it.
`ifndef BOUNDED_STACK_WITH_PALINDROME_CHECK_DEFINES_SVH
`define BOUNDED_STACK_WITH_PALINDROME_CHECK_DEFINES_SVH

// Checked property, ignored while reset is high
`define BSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, live during reset as well
`define BSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bsp_pkg.sv
// Package for the bounded stack block: sizes, operation and status codes,
// and the controller state type. No dependencies.
`default_nettype none

package bsp_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // operation codes carried on req_mode
   localparam logic [1:0] MODE_PUSH    = 2'd0;
   localparam logic [1:0] MODE_POP     = 2'd1;
   localparam logic [1:0] MODE_READOUT = 2'd2;
   localparam logic [1:0] MODE_PAL     = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_WALK,
      S_PAL
   } state_type;

endpackage

`default_nettype wire

>>> hdl/bounded_stack_with_palindrome_check.sv
// Bounded LIFO stack with top-to-bottom readout and palindrome check.
// Push: one beat after accept, next item in the next cycle. Pop: result beat after the
// store read and result registers, busy while in S_POP. Readout: one beat per element,
// top first, each beat after the store read and result registers, busy until the bottom
// beat. Palindrome: one pair per cycle over two read ports, then a registered result.
// Synchronous reset empties the stack; store not cleared; results never stall.
`default_nettype none

module bounded_stack_with_palindrome_check (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_mode,
   input  wire logic signed [bsp_pkg::DATA_W-1:0] req_push_value,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic signed [bsp_pkg::DATA_W-1:0]      rsp_data_out,
   output logic                                   rsp_is_palindrome,
   output logic                                   rsp_last
);
   import bsp_pkg::*;
   `include "bounded_stack_with_palindrome_check_defines.svh"

   state_type state_ff, state_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;      // readout index, or high index in check
   logic [IDX_W-1:0] lo_ff, lo_in;        // low index in check
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_status_ff, out_status_in;
   logic signed [DATA_W-1:0] out_data_ff, out_data_in;
   logic             out_pal_ff, out_pal_in;
   logic             out_last_ff, out_last_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr, rd_addr_a, rd_addr_b;
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [DATA_W-1:0] mem [DEPTH];

   logic             accept;
   logic [CNT_W-1:0] fill_dec;
   logic [IDX_W-1:0] top_idx;
   logic [IDX_W:0]   span;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign fill_dec = fill_count_ff - 1'b1;
   assign top_idx  = fill_dec[IDX_W-1:0];
   assign span     = {1'b0, ptr_ff} - {1'b0, lo_ff};

   // stack store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_push_value;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         out_valid_ff  <= out_valid_in;
      end
      ptr_ff        <= ptr_in;
      lo_ff         <= lo_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
      out_pal_ff    <= out_pal_in;
      out_last_ff   <= out_last_in;
   end

   // next state, store access and result beat
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      ptr_in        = ptr_ff;
      lo_in         = lo_ff;
      out_valid_in  = 1'b0;
      out_status_in = ST_OK;
      out_data_in   = '0;
      out_pal_in    = 1'b0;
      out_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = fill_count_ff[IDX_W-1:0];
      rd_addr_a     = top_idx;
      rd_addr_b     = top_idx;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_PUSH: begin
                     out_valid_in = 1'b1;
                     if (fill_count_ff == CNT_W'(DEPTH)) begin
                        out_status_in = ST_OVERFLOW;
                     end else begin
                        wr_en         = 1'b1;
                        fill_count_in = fill_count_ff + 1'b1;
                     end
                  end
                  MODE_POP: begin
                     if (fill_count_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EMPTY;
                     end else begin
                        fill_count_in = fill_dec;
                        state_in      = S_POP;
                     end
                  end
                  MODE_READOUT: begin
                     if (fill_count_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EMPTY;
                     end else begin
                        ptr_in   = top_idx;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     // palindrome check: first pair is bottom and top
                     if (fill_count_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EMPTY;
                     end else begin
                        rd_addr_a = '0;
                        lo_in     = '0;
                        ptr_in    = top_idx;
                        state_in  = S_PAL;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            out_valid_in = 1'b1;
            out_data_in  = rd_a_ff;
            state_in     = S_IDLE;
         end
         S_WALK: begin
            // one element per cycle, next read issued below the current one
            out_valid_in = 1'b1;
            out_data_in  = rd_a_ff;
            out_last_in  = (ptr_ff == '0);
            rd_addr_a    = ptr_ff - 1'b1;
            ptr_in       = ptr_ff - 1'b1;
            if (ptr_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         S_PAL: begin
            // compare one pair; continue inward while pairs remain
            rd_addr_a = lo_ff + 1'b1;
            rd_addr_b = ptr_ff - 1'b1;
            if (rd_a_ff != rd_b_ff) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (span > (IDX_W + 1)'(2)) begin
               lo_in  = lo_ff + 1'b1;
               ptr_in = ptr_ff - 1'b1;
            end else begin
               out_valid_in = 1'b1;
               out_pal_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_data_out      = out_data_ff;
   assign rsp_is_palindrome = out_pal_ff;
   assign rsp_last          = out_last_ff;

   // checks on fill tracking and beat sequencing
   `BSP_ASSERT_ALWAYS(a_fill_bound, clock, !reset |-> (fill_count_ff <= CNT_W'(DEPTH)), "fill count above depth")
   `BSP_ASSERT(a_ovf_full, clock, reset, (rsp_valid && rsp_status == ST_OVERFLOW) |-> (fill_count_ff == CNT_W'(DEPTH)), "overflow reported on a stack that is not full")
   `BSP_ASSERT(a_empty_zero, clock, reset, (rsp_valid && rsp_status == ST_EMPTY) |-> (fill_count_ff == '0), "empty reported on a stack that holds data")
   `BSP_ASSERT(a_walk_end, clock, reset, (state_ff == S_WALK && ptr_ff == '0) |=> (rsp_valid && rsp_last && state_ff == S_IDLE), "readout did not close with a last beat")

endmodule

`default_nettype wire

>>> sim/bsp_checker.sv
// Checker for the bounded stack block: watches the request and result channels,
// keeps its own copy of the stack and compares every result beat field by field.
// Depends on bsp_pkg for sizes, operation codes and status codes.
`timescale 1ns / 1ps

module bsp_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [1:0]                 req_mode,
   input  wire logic [bsp_pkg::DATA_W-1:0] req_push_value,
   input  wire logic                       rsp_valid,
   input  wire logic [1:0]                 rsp_status,
   input  wire logic [bsp_pkg::DATA_W-1:0] rsp_data_out,
   input  wire logic                       rsp_is_palindrome,
   input  wire logic                       rsp_last,
   output int                              error_count,
   output int                              expected_left
);
   import bsp_pkg::*;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] data_out;
      logic              is_palindrome;
      logic              last;
   } stack_beat_type;

   // shadow stack; entries at or above shadow_fill are never read
   logic [DATA_W-1:0] shadow_words [DEPTH];
   int                shadow_fill;
   stack_beat_type    beat_q [$];

   function automatic stack_beat_type make_beat(input logic [1:0] status,
                                                input logic [DATA_W-1:0] data,
                                                input logic pal, input logic fin);
      stack_beat_type b;
      b.status        = status;
      b.data_out      = data;
      b.is_palindrome = pal;
      b.last          = fin;
      return b;
   endfunction

   // apply one accepted operation to the shadow stack, queue its result beats
   task automatic apply_stack_op(input logic [1:0] op, input logic [DATA_W-1:0] word);
      int hi;
      bit same;
      case (op)
         MODE_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               beat_q.push_back(make_beat(ST_OVERFLOW, '0, 1'b0, 1'b1));
            end else begin
               shadow_words[shadow_fill] = word;
               shadow_fill++;
               beat_q.push_back(make_beat(ST_OK, '0, 1'b0, 1'b1));
            end
         end
         MODE_POP: begin
            if (shadow_fill == 0) begin
               beat_q.push_back(make_beat(ST_EMPTY, '0, 1'b0, 1'b1));
            end else begin
               shadow_fill--;
               beat_q.push_back(make_beat(ST_OK, shadow_words[shadow_fill], 1'b0, 1'b1));
            end
         end
         MODE_READOUT: begin
            if (shadow_fill == 0) begin
               beat_q.push_back(make_beat(ST_EMPTY, '0, 1'b0, 1'b1));
            end else begin
               // top first, last flag on the bottom word
               for (int k = shadow_fill - 1; k >= 0; k--)
                  beat_q.push_back(make_beat(ST_OK, shadow_words[k], 1'b0, k == 0));
            end
         end
         default: begin
            if (shadow_fill == 0) begin
               beat_q.push_back(make_beat(ST_EMPTY, '0, 1'b0, 1'b1));
            end else begin
               hi   = shadow_fill - 1;
               same = 1'b1;
               for (int k = 0; k <= hi / 2; k++)
                  if (shadow_words[k] != shadow_words[hi - k]) same = 1'b0;
               beat_q.push_back(make_beat(ST_OK, '0, same, 1'b1));
            end
         end
      endcase
   endtask

   // predict on accept first, then compare, so a same-cycle result still lines up
   always @(posedge clock) begin
      stack_beat_type want;
      int             bad;
      bad = 0;
      if (reset) begin
         shadow_fill = 0;
         beat_q.delete();
         error_count <= 0;
      end else begin
         if (start && !busy) apply_stack_op(req_mode, req_push_value);
         if (rsp_valid) begin
            if (beat_q.size() == 0) begin
               $error("unexpected result beat: status %0d data_out %0d is_palindrome %0d last %0d",
                      rsp_status, $signed(rsp_data_out), rsp_is_palindrome, rsp_last);
               bad++;
            end else begin
               want = beat_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  bad++;
               end
               if (rsp_data_out !== want.data_out) begin
                  $error("data_out: expected %0d, actual %0d",
                         $signed(want.data_out), $signed(rsp_data_out));
                  bad++;
               end
               if (rsp_is_palindrome !== want.is_palindrome) begin
                  $error("is_palindrome: expected %0d, actual %0d",
                         want.is_palindrome, rsp_is_palindrome);
                  bad++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  bad++;
               end
            end
         end
         error_count <= error_count + bad;
      end
      expected_left <= beat_q.size();
   end

endmodule

>>> sim/tb.sv
// Top of the bounded stack testbench: clock, reset, stimulus and verdict.
// Depends on bsp_pkg, the block under test and bsp_checker.
`timescale 1ns / 1ps

module tb;
   import bsp_pkg::*;

   localparam int RANDOM_ITEMS = 85;
   localparam int IDLE_LIMIT   = 400;
   localparam int TAIL_CYCLES  = 2 * DEPTH + 8;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     start          = 1'b0;
   logic [1:0]               req_mode       = MODE_PUSH;
   logic signed [DATA_W-1:0] req_push_value = '0;
   wire logic                busy;
   wire logic                rsp_valid;
   wire logic [1:0]          rsp_status;
   wire logic [DATA_W-1:0]   rsp_data_out;
   wire logic                rsp_is_palindrome;
   wire logic                rsp_last;
   int                       error_count;
   int                       expected_left;

   int stack_fill  = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   bounded_stack_with_palindrome_check dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_data_out      (rsp_data_out),
      .rsp_is_palindrome (rsp_is_palindrome),
      .rsp_last          (rsp_last)
   );

   bsp_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_data_out      (rsp_data_out),
      .rsp_is_palindrome (rsp_is_palindrome),
      .rsp_last          (rsp_last),
      .error_count       (error_count),
      .expected_left     (expected_left)
   );

   // watchdog: too long without an accepted request or result beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // extremes and small values often, so palindromes and repeats show up
   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3, 4:    return $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   // drive one request beat, hold it until accepted, then maybe leave a gap
   task automatic send_beat(input logic [1:0] op, input logic [DATA_W-1:0] word);
      int gap;
      start          <= 1'b1;
      req_mode       <= op;
      req_push_value <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (op == MODE_PUSH && stack_fill < DEPTH) stack_fill++;
      if (op == MODE_POP && stack_fill > 0) stack_fill--;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         case ($urandom_range(0, 7))
            0:       gap = 0;
            1:       gap = $urandom_range(5, 20);
            default: gap = $urandom_range(1, 4);
         endcase
         // junk on the request fields while start is low
         for (int g = 0; g < gap; g++) begin
            start          <= 1'b0;
            req_mode       <= 2'($urandom_range(0, 3));
            req_push_value <= $urandom();
            @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 6);
      end
   endtask

   // hold off until every predicted beat has arrived
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   task automatic run_episode();
      logic [DATA_W-1:0] vals [DEPTH];
      int                len;
      int                idx;
      case ($urandom_range(0, 9))
         // build a (possibly broken) palindrome from empty and check it
         0, 1, 2, 3: begin
            while (stack_fill > 0) send_beat(MODE_POP, rand_word());
            len = ($urandom_range(0, 4) == 0) ? DEPTH : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) vals[k] = rand_word();
            for (int k = 0; k < len / 2; k++) vals[len - 1 - k] = vals[k];
            if ($urandom_range(0, 1)) begin
               idx       = $urandom_range(0, len - 1);
               vals[idx] = vals[idx] ^ (32'd1 << $urandom_range(0, 31));
            end
            for (int k = 0; k < len; k++) send_beat(MODE_PUSH, vals[k]);
            send_beat(MODE_PAL, rand_word());
            if ($urandom_range(0, 1)) send_beat(MODE_READOUT, rand_word());
            repeat ($urandom_range(0, len)) send_beat(MODE_POP, rand_word());
            send_beat(MODE_PAL, rand_word());
         end
         // fill to the top and push past it
         4, 5: begin
            while (stack_fill < DEPTH) send_beat(MODE_PUSH, rand_word());
            repeat ($urandom_range(1, 3)) send_beat(MODE_PUSH, rand_word());
            send_beat(MODE_PAL, rand_word());
            send_beat(MODE_READOUT, rand_word());
         end
         // any mode, any value
         6, 7: begin
            repeat ($urandom_range(3, 10)) send_beat(2'($urandom_range(0, 3)), rand_word());
         end
         // drain, then pop, readout and palindrome check on an empty stack
         8: begin
            while (stack_fill > 0) send_beat(MODE_POP, rand_word());
            repeat ($urandom_range(1, 2)) send_beat(MODE_POP, rand_word());
            send_beat(MODE_READOUT, rand_word());
            send_beat(MODE_PAL, rand_word());
         end
         default: begin
            wait_drained();
            repeat ($urandom_range(1, 4))
               send_beat($urandom_range(0, 1) ? MODE_PUSH : MODE_POP, rand_word());
         end
      endcase
   endtask

   initial begin
      logic [DATA_W-1:0] mirror [DEPTH];
      int                directed_count;
      burst_left = $urandom_range(0, 6);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-stack cases
      send_beat(MODE_POP, 32'h7fff_ffff);
      send_beat(MODE_READOUT, 32'hffff_ffff);
      send_beat(MODE_PAL, 32'h0);

      // full-depth palindrome holding the extreme words
      mirror[0] = 32'h8000_0000;
      mirror[1] = 32'h7fff_ffff;
      mirror[2] = 32'h0;
      mirror[3] = 32'hffff_ffff;
      for (int k = 4; k < DEPTH / 2; k++) mirror[k] = $urandom();
      for (int k = 0; k < DEPTH / 2; k++) mirror[DEPTH - 1 - k] = mirror[k];

      // single element: palindrome and one-beat readout
      send_beat(MODE_PUSH, mirror[0]);
      send_beat(MODE_PAL, $urandom());
      send_beat(MODE_READOUT, $urandom());
      for (int k = 1; k < DEPTH; k++) send_beat(MODE_PUSH, mirror[k]);

      // overflow, full palindrome, full readout, pop of the top
      send_beat(MODE_PUSH, 32'h7fff_ffff);
      send_beat(MODE_PAL, $urandom());
      send_beat(MODE_READOUT, $urandom());
      send_beat(MODE_POP, $urandom());
      wait_drained();
      directed_count = items_sent;

      // random episodes
      while (items_sent < directed_count + RANDOM_ITEMS) run_episode();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_left == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/bsp_pkg.sv
hdl/bounded_stack_with_palindrome_check.sv
sim/bsp_checker.sv
sim/tb.sv
